[rtl/core/mcdc_pkg.sv]
// shared types and constants for the module call-depth coverage tracker
package mcdc_pkg;

  localparam int STACK_LIMIT = 255;
  localparam int MAP_ENTRIES = 65536;

  localparam int LEVEL_W     = 8;
  localparam int STACK_DEPTH = 1 << LEVEL_W;
  localparam int MOD_W       = 16;
  localparam int REP_W       = 16;
  localparam int COUNT_W     = 32;
  localparam int MAP_W       = 8;
  localparam int MAP_AW      = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CLR_LEN     = (MAP_ENTRIES > STACK_DEPTH) ? MAP_ENTRIES : STACK_DEPTH;
  localparam int CLR_W       = $clog2(CLR_LEN);

  localparam logic [MAP_W-1:0] MAP_ENTRY0_RESET = 8'd75;

  typedef enum logic [1:0] {
    KIND_RESET  = 2'd0,
    KIND_ENTER  = 2'd1,
    KIND_RETURN = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [MOD_W-1:0] module_req;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] depth;
    logic [COUNT_W-1:0] unique_count;
    logic [MAP_W-1:0]   map_value;
    logic               first_seen;
    logic               at_limit;
  } res_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } status_t;

endpackage

[rtl/core/mcdc_ctrl.sv]
// controller state machine: clearing pass, accept and execute sequencing
module mcdc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mcdc_pkg::status_t status_i,
  output mcdc_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import mcdc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (state_q == ST_EXEC);
      unique case (state_q)
        ST_CLEAR: begin
          if (status_i.clr_done) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.clear  = (state_q == ST_CLEAR);
    cmd_o.accept = (state_q == ST_IDLE) && start_i;
    cmd_o.exec   = (state_q == ST_EXEC);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = valid_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == ST_IDLE))
    else $error("result beat outside idle");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EXEC))
    else $error("accepted beat not executed");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> valid_q)
    else $error("executed beat without result");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> ((state_q == ST_CLEAR || state_q == ST_IDLE) && !valid_q))
    else $error("activity during clearing pass");

endmodule

[rtl/core/mcdc_dp.sv]
// datapath: call stack memories, coverage map memory, level and first-seen counter
module mcdc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcdc_pkg::cmd_t    cmd_i,
  output mcdc_pkg::status_t status_o,
  input  mcdc_pkg::req_t    req_i,
  input  logic              tracking_enable_we_i,
  input  logic              tracking_enable_i,
  output mcdc_pkg::res_t    res_o
);
  import mcdc_pkg::*;

  logic [MOD_W-1:0] stk_mod_mem [STACK_DEPTH];
  logic [REP_W-1:0] stk_rep_mem [STACK_DEPTH];
  logic [MAP_W-1:0] map_mem     [MAP_ENTRIES];

  logic               en_q;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [CLR_W-1:0]   clr_cnt_q;

  kind_e              kind_q;
  logic [MOD_W-1:0]   mod_q;
  logic [MOD_W-1:0]   stk_mod_rd_q;
  logic [REP_W-1:0]   stk_rep_rd_q;
  logic [MAP_W-1:0]   map_rd_q;
  res_t               res_q;

  logic               stk_mod_we, stk_rep_we, map_we;
  logic [LEVEL_W-1:0] stk_wa;
  logic [MOD_W-1:0]   stk_mod_wd;
  logic [REP_W-1:0]   stk_rep_wd;
  logic [MAP_AW-1:0]  map_wa;
  logic [MAP_W-1:0]   map_wd;

  logic               ex_mod_we, ex_rep_we, ex_map_we;
  logic [LEVEL_W-1:0] ex_wa;
  logic [MOD_W-1:0]   ex_mod_wd;
  logic [REP_W-1:0]   ex_rep_wd;
  logic [MAP_W-1:0]   ex_map_wd;
  logic               active, in_range, first;
  logic [LEVEL_W-1:0] push_lvl;
  logic [REP_W-1:0]   rep_dec;

  assign active   = en_q && (level_q != LEVEL_W'(STACK_LIMIT));
  assign in_range = ({16'd0, mod_q} < 32'(MAP_ENTRIES));
  assign push_lvl = level_q + LEVEL_W'(1);
  assign rep_dec  = stk_rep_rd_q - REP_W'(1);

  always_comb begin
    level_d   = level_q;
    cnt_d     = cnt_q;
    ex_mod_we = 1'b0;
    ex_rep_we = 1'b0;
    ex_map_we = 1'b0;
    ex_wa     = level_q;
    ex_mod_wd = mod_q;
    ex_rep_wd = stk_rep_rd_q;
    ex_map_wd = push_lvl;
    first     = 1'b0;
    case (kind_q)
      KIND_RESET: begin
        level_d   = '0;
        ex_mod_we = 1'b1;
        ex_wa     = '0;
        ex_mod_wd = '0;
      end
      KIND_ENTER: begin
        if (active) begin
          if (stk_mod_rd_q == mod_q) begin
            ex_rep_we = 1'b1;
            ex_rep_wd = stk_rep_rd_q + REP_W'(1);
          end else begin
            level_d   = push_lvl;
            ex_wa     = push_lvl;
            ex_mod_we = 1'b1;
            ex_rep_we = 1'b1;
            ex_rep_wd = REP_W'(1);
            if (in_range) begin
              if (map_rd_q == '0) begin
                ex_map_we = 1'b1;
                cnt_d     = cnt_q + COUNT_W'(1);
                first     = 1'b1;
              end else if (push_lvl < map_rd_q) begin
                ex_map_we = 1'b1;
              end
            end
          end
        end
      end
      KIND_RETURN: begin
        if (active) begin
          ex_rep_we = 1'b1;
          ex_rep_wd = rep_dec;
          if ((rep_dec == '0) && (level_q != '0)) level_d = level_q - LEVEL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // clearing pass shares the write ports
  always_comb begin
    if (cmd_i.clear) begin
      stk_mod_we = (32'(clr_cnt_q) < STACK_DEPTH);
      stk_rep_we = (32'(clr_cnt_q) < STACK_DEPTH);
      map_we     = (32'(clr_cnt_q) < MAP_ENTRIES);
      stk_wa     = clr_cnt_q[LEVEL_W-1:0];
      stk_mod_wd = '0;
      stk_rep_wd = '0;
      map_wa     = clr_cnt_q[MAP_AW-1:0];
      map_wd     = (clr_cnt_q == '0) ? MAP_ENTRY0_RESET : '0;
    end else begin
      stk_mod_we = cmd_i.exec && ex_mod_we;
      stk_rep_we = cmd_i.exec && ex_rep_we;
      map_we     = cmd_i.exec && ex_map_we;
      stk_wa     = ex_wa;
      stk_mod_wd = ex_mod_wd;
      stk_rep_wd = ex_rep_wd;
      map_wa     = mod_q[MAP_AW-1:0];
      map_wd     = ex_map_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_mod_we) stk_mod_mem[stk_wa] <= stk_mod_wd;
    if (stk_rep_we) stk_rep_mem[stk_wa] <= stk_rep_wd;
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd_i.accept) begin
      stk_mod_rd_q <= stk_mod_mem[level_q];
      stk_rep_rd_q <= stk_rep_mem[level_q];
      map_rd_q     <= map_mem[req_i.module_req[MAP_AW-1:0]];
      kind_q       <= req_i.kind;
      mod_q        <= req_i.module_req;
    end
    if (cmd_i.exec) begin
      res_q.depth        <= level_d;
      res_q.unique_count <= cnt_d;
      res_q.map_value    <= !in_range ? '0 : (ex_map_we ? ex_map_wd : map_rd_q);
      res_q.first_seen   <= first;
      res_q.at_limit     <= (level_d == LEVEL_W'(STACK_LIMIT));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b0;
      level_q   <= '0;
      cnt_q     <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (tracking_enable_we_i) en_q <= tracking_enable_i;
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      if (cmd_i.exec) begin
        level_q <= level_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  assign status_o.clr_done = cmd_i.clear && (clr_cnt_q == CLR_W'(CLR_LEN - 1));
  assign res_o             = res_q;

endmodule

[rtl/core/module_call_depth_coverage.sv]
// top level of the module call-depth coverage tracker
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+--------------------------
//   request   | start_i, busy_o               | req_i (kind, module_req)
//   result    | done_o (one-cycle strobe)     | res_o
//   config    | tracking_enable_we_i          | tracking_enable_i
//
// each beat is accepted, then executed: the accept edge reads the stack and coverage
// map memories into registers, and the execute state writes them back and loads the result register
// the result strobe rises as the result register loads, back in idle; a new beat may be accepted then
// after reset a clearing pass over all 65536 map entries (one map entry a cycle) keeps busy_o high
// the receiver cannot stall; done_o is never held
module module_call_depth_coverage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mcdc_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output mcdc_pkg::res_t res_o,
  input  logic           tracking_enable_we_i,
  input  logic           tracking_enable_i
);
  import mcdc_pkg::*;

  cmd_t    cmd;
  status_t status;

  mcdc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  mcdc_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .req_i                (req_i),
    .tracking_enable_we_i (tracking_enable_we_i),
    .tracking_enable_i    (tracking_enable_i),
    .res_o                (res_o)
  );

endmodule
